>>> rtl/mspc_pkg.sv
// Package for the motor speed PI controller: sizing constants, register
// indexes and the configuration bundle. No dependencies.
package mspc_pkg;

  localparam int unsigned RING_DEPTH     = 8;
  localparam int unsigned FETCH_INTERVAL = 64;
  localparam int unsigned PROP_SHIFT     = 4;
  localparam int unsigned INTEG_SHIFT    = 4;

  localparam int unsigned PHASE_W = $clog2(FETCH_INTERVAL);
  localparam int unsigned SLOT_W  = $clog2(RING_DEPTH);

  // shared multiplier operand and product widths
  localparam int unsigned MUL_W  = 10;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // duty after reset: half of the reset value of duty_max (255)
  localparam logic [7:0] DUTY_RESET = 8'd127;

  typedef enum logic [2:0] {
    REG_MIN_PWM         = 3'd0,
    REG_MAX_RPM         = 3'd1,
    REG_PROP_GAIN       = 3'd2,
    REG_INTEG_GAIN      = 3'd3,
    REG_INTEGRAL_LOW    = 3'd4,
    REG_INTEGRAL_HIGH   = 3'd5,
    REG_PRESS_THRESHOLD = 3'd6,
    REG_DUTY_MAX        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        [7:0] min_pwm;
    logic        [7:0] max_rpm;
    logic        [7:0] prop_gain;
    logic        [7:0] integ_gain;
    logic signed [7:0] integral_low;
    logic        [6:0] integral_high;
    logic        [7:0] press_threshold;
    logic        [7:0] duty_max;
  } cfg_t;

endpackage

>>> rtl/mspc_if.sv
// Valid/ready channel interfaces for the tick items and the result items.
// Depends on nothing.
interface mspc_item_if;
  logic       valid;
  logic       ready;
  logic [3:0] hall_pulses;
  logic [7:0] normal_adc;
  logic [7:0] turbo_adc;

  modport source (output valid, output hall_pulses, output normal_adc,
                  output turbo_adc, input ready);
  modport sink   (input valid, input hall_pulses, input normal_adc,
                  input turbo_adc, output ready);
endinterface

interface mspc_result_if;
  logic              valid;
  logic              ready;
  logic        [7:0] duty;
  logic        [7:0] speed;
  logic              updated;
  logic signed [7:0] integral;

  modport source (output valid, output duty, output speed, output updated,
                  output integral, input ready);
  modport sink   (input valid, input duty, input speed, input updated,
                  input integral, output ready);
endinterface

>>> rtl/mspc_cfg_regs.sv
// Configuration register file of the motor speed PI controller.
// Depends on mspc_pkg.
module mspc_cfg_regs
  import mspc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_pwm         <= 8'd1;
      cfg.max_rpm         <= 8'd255;
      cfg.prop_gain       <= 8'd16;
      cfg.integ_gain      <= 8'd16;
      cfg.integral_low    <= -8'sd64;
      cfg.integral_high   <= 7'd64;
      cfg.press_threshold <= 8'd16;
      cfg.duty_max        <= 8'd255;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_PWM:         cfg.min_pwm         <= cfg_wdata;
        REG_MAX_RPM:         cfg.max_rpm         <= cfg_wdata;
        REG_PROP_GAIN:       cfg.prop_gain       <= cfg_wdata;
        REG_INTEG_GAIN:      cfg.integ_gain      <= cfg_wdata;
        REG_INTEGRAL_LOW:    cfg.integral_low    <= $signed(cfg_wdata);
        REG_INTEGRAL_HIGH:   cfg.integral_high   <= cfg_wdata[6:0];
        REG_PRESS_THRESHOLD: cfg.press_threshold <= cfg_wdata;
        REG_DUTY_MAX:        cfg.duty_max        <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/mspc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mspc_pkg.
module mspc_mul
  import mspc_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/motor_speed_pi_controller.sv
// Motor speed PI controller. One tick item (hall edges plus two knob ADC
// samples) gives one result item. A tick that does not end a fetch interval
// only adds its hall edges to the pulse total; its result is registered at
// the transfer. Every FETCH_INTERVAL-th tick stores the total in the ring,
// measures speed and runs a PI step through states S_EXP to S_DONE, using
// the single shared 10x10 multiplier four times in order (setpoint scale,
// P term, I term, duty mapping). No new tick is taken meanwhile.
// The duty starts at 127 after reset. Config writes are for idle periods.
module motor_speed_pi_controller
  import mspc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  mspc_item_if.sink            item_in,
  mspc_result_if.source        result_out,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [7:0]           cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXP, S_ERR, S_PMUL, S_IMUL, S_SUM, S_DUTY, S_DONE
  } state_t;

  cfg_t cfg;

  mspc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // shared multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  mspc_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // control state
  state_t              state;
  logic [PHASE_W-1:0]  tick_phase;
  logic [7:0]          pulse_total;
  logic [SLOT_W-1:0]   ring_slot;
  logic                ring_filled;
  logic                out_valid;
  logic                updated;

  // datapath registers
  logic [7:0]          pulse_ring [RING_DEPTH];
  logic [7:0]          speed_now;
  logic signed [7:0]   error_integral;
  logic [7:0]          duty_now;
  logic [7:0]          adc_sel;
  logic signed [8:0]   diff;
  logic signed [PROD_W-1:0] acc;
  logic [7:0]          target;

  // ---------------- tick intake ----------------
  logic                in_fire;
  logic                fetch;
  logic [7:0]          total_next;
  logic [SLOT_W-1:0]   slot_next;
  logic                filled_next;
  logic [SLOT_W-1:0]   oldest_idx;
  logic [7:0]          oldest;

  assign item_in.ready = (state == S_IDLE) && (!out_valid || result_out.ready);
  assign in_fire       = item_in.valid && item_in.ready;

  assign fetch       = (tick_phase == PHASE_W'(FETCH_INTERVAL - 1));
  assign total_next  = pulse_total + {4'd0, item_in.hall_pulses};
  assign slot_next   = (ring_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
  assign filled_next = ring_filled || (slot_next == '0);
  // before the ring has wrapped, slot 0 stands in for the oldest entry
  assign oldest_idx  = filled_next ? slot_next : '0;
  // forward the total being written this transfer
  assign oldest      = (oldest_idx == ring_slot) ? total_next : pulse_ring[oldest_idx];

  // ---------------- PI datapath ----------------
  logic [7:0]               expected;
  logic signed [8:0]        diff_c;
  logic signed [9:0]        integ_sum;
  logic signed [9:0]        integ_hi;
  logic signed [9:0]        integ_lo;
  logic signed [9:0]        integ_clamp;
  logic signed [PROD_W-1:0] acc_sum;
  logic [7:0]               target_c;
  logic                     min_over;
  logic [7:0]               span;

  assign expected  = prod[15:8];
  assign diff_c    = $signed({1'b0, expected}) - $signed({1'b0, speed_now});
  assign integ_sum = {{2{error_integral[7]}}, error_integral} + {diff_c[8], diff_c};
  assign integ_hi  = $signed({3'b000, cfg.integral_high});
  assign integ_lo  = {{2{cfg.integral_low[7]}}, cfg.integral_low};

  // high clamp first, then low clamp: crossed limits end at the low one
  always_comb begin
    integ_clamp = integ_sum;
    if (integ_clamp >= integ_hi) integ_clamp = integ_hi;
    if (integ_clamp <= integ_lo) integ_clamp = integ_lo;
  end

  // arithmetic shifts round toward minus infinity
  assign acc_sum = acc + (prod >>> INTEG_SHIFT);

  always_comb begin
    if (acc_sum[PROD_W-1]) begin
      target_c = 8'd0;
    end else if (|acc_sum[PROD_W-2:8]) begin
      target_c = 8'd255;
    end else begin
      target_c = acc_sum[7:0];
    end
  end

  assign min_over = (cfg.min_pwm >= cfg.duty_max);
  assign span     = cfg.duty_max - cfg.min_pwm;

  // multiplier operand select
  always_comb begin
    unique case (state)
      S_EXP: begin
        mul_a = $signed({2'b00, adc_sel});
        mul_b = $signed({2'b00, cfg.max_rpm});
      end
      S_PMUL: begin
        mul_a = {diff[8], diff};
        mul_b = $signed({2'b00, cfg.prop_gain});
      end
      S_IMUL: begin
        mul_a = {{2{error_integral[7]}}, error_integral};
        mul_b = $signed({2'b00, cfg.integ_gain});
      end
      S_DUTY: begin
        mul_a = $signed({2'b00, span});
        mul_b = $signed({2'b00, target});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tick_phase     <= '0;
      pulse_total    <= 8'd1;
      ring_slot      <= '0;
      ring_filled    <= 1'b0;
      out_valid      <= 1'b0;
      updated        <= 1'b0;
      speed_now      <= 8'd0;
      error_integral <= 8'sd0;
      duty_now       <= DUTY_RESET;
    end else begin
      // a result taken together with a plain tick is replaced by that tick's result
      if (out_valid && result_out.ready && !(in_fire && !fetch)) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pulse_total <= total_next;
            if (fetch) begin
              tick_phase             <= '0;
              pulse_ring[ring_slot]  <= total_next;
              ring_slot              <= slot_next;
              ring_filled            <= filled_next;
              speed_now              <= total_next - oldest;
              adc_sel                <= (item_in.normal_adc >= cfg.press_threshold) ?
                                        item_in.normal_adc : item_in.turbo_adc;
              state                  <= S_EXP;
            end else begin
              tick_phase <= tick_phase + 1'b1;
              updated    <= 1'b0;
              out_valid  <= 1'b1;
            end
          end
        end
        S_EXP: state <= S_ERR;
        S_ERR: begin
          diff           <= diff_c;
          error_integral <= integ_clamp[7:0];
          state          <= S_PMUL;
        end
        S_PMUL: state <= S_IMUL;
        S_IMUL: begin
          acc   <= $signed({{(PROD_W - 8){1'b0}}, speed_now}) + (prod >>> PROP_SHIFT);
          state <= S_SUM;
        end
        S_SUM: begin
          target <= target_c;
          state  <= S_DUTY;
        end
        S_DUTY: state <= S_DONE;
        S_DONE: begin
          duty_now  <= min_over ? cfg.duty_max : cfg.min_pwm + prod[15:8];
          updated   <= 1'b1;
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.duty     = duty_now;
  assign result_out.speed    = speed_now;
  assign result_out.updated  = updated;
  assign result_out.integral = error_integral;

endmodule
